// ===== sv/mcr_pkg.sv =====
// Shared types, constants and the microcode program of the move conflict resolver.
// Depends on nothing; the sequencer, the datapath and the top level import it.
package mcr_pkg;

	// Sizes of the agent table and of the grid.
	localparam int AGENTS      = 16;
	localparam int GRID_COLS   = 64;
	localparam int GRID_ROWS   = 64;
	localparam int MAP_DEPTH   = GRID_COLS * GRID_ROWS;
	localparam int MAP_AW      = $clog2(MAP_DEPTH);
	localparam int AGENT_W     = 4;
	localparam int AGENT_IDX_W = $clog2(AGENTS);
	localparam int CNT_W       = $clog2(AGENTS + 1);
	localparam int COORD_W     = 6;
	localparam int CELL_W      = 1 + 2 * COORD_W;
	localparam int OWN_W       = 1 + AGENT_IDX_W;

	typedef logic [MAP_AW-1:0] map_addr_t;

	// Packed as valid, row, column; an absent cell is all zero.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} cell_t;

	// One owner map entry; an empty entry is all zero.
	typedef struct packed {
		logic                   valid;
		logic [AGENT_IDX_W-1:0] id;
	} own_t;

	// Micro-operations executed by the datapath.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_SWEEP,
		OP_LOAD,
		OP_LOAD_A,
		OP_RD_A,
		OP_RD_OTHER,
		OP_P1_CHK,
		OP_P1_DEC,
		OP_INC_K,
		OP_ZERO_K,
		OP_CLEAR,
		OP_P2_RD,
		OP_P2_CHK,
		OP_P2_WR,
		OP_P3_CHKA,
		OP_LOAD_OTHER,
		OP_P3_DEC,
		OP_EMIT,
		OP_END_BATCH
	} op_t;

	// Jump conditions tested by the sequencer.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_K_EQ_CNT,
		C_K_EQ_AGENTS,
		C_PROP_OFF,
		C_CUR_OFF,
		C_NO_OTHER,
		C_CLR_BUSY,
		C_SWEEP_BUSY,
		C_NOT_GO
	} cond_t;

	// Program steps. The init sweep must sit right before the idle step.
	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_P1_TOP,
		ST_P1_RD,
		ST_P1_CHK,
		ST_P1_DEC,
		ST_P1_NEXT,
		ST_P1_END,
		ST_CLR1,
		ST_P2_RD,
		ST_P2_CHK,
		ST_P2_WR,
		ST_P2_NEXT,
		ST_P3_INIT,
		ST_P3_TOP,
		ST_P3_RDA,
		ST_P3_CHKA,
		ST_P3_OWN,
		ST_P3_RDO,
		ST_P3_DEC,
		ST_P3_NEXT,
		ST_OUT_INIT,
		ST_OUT_TOP,
		ST_OUT_RD,
		ST_OUT_EMIT,
		ST_OUT_END,
		ST_CLR2,
		ST_FINISH
	} step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Status flags from the datapath, one per jump condition other than never and always.
	typedef struct packed {
		logic k_eq_cnt;
		logic k_eq_agents;
		logic prop_off;
		logic cur_off;
		logic no_other;
		logic clr_busy;
		logic sweep_busy;
		logic not_go;
	} flags_t;

	function automatic logic cell_on_map(cell_t c_in);
		return c_in.valid && (32'(c_in.x) < GRID_COLS) && (32'(c_in.y) < GRID_ROWS);
	endfunction

	function automatic map_addr_t cell_addr(cell_t c_in);
		return MAP_AW'(32'(c_in.y) * GRID_COLS + 32'(c_in.x));
	endfunction

	// The control store: when the condition holds, jump to the target, else step on.
	function automatic ctrl_t mc_rom(step_t s);
		ctrl_t w;
		unique case (s)
			ST_INIT:     w = '{OP_SWEEP,      C_SWEEP_BUSY,  ST_INIT};
			ST_IDLE:     w = '{OP_LOAD,       C_NOT_GO,      ST_IDLE};
			ST_P1_TOP:   w = '{OP_LOAD_A,     C_K_EQ_CNT,    ST_P1_END};
			ST_P1_RD:    w = '{OP_RD_A,       C_NEVER,       ST_IDLE};
			ST_P1_CHK:   w = '{OP_P1_CHK,     C_PROP_OFF,    ST_P1_NEXT};
			ST_P1_DEC:   w = '{OP_P1_DEC,     C_NEVER,       ST_IDLE};
			ST_P1_NEXT:  w = '{OP_INC_K,      C_ALWAYS,      ST_P1_TOP};
			ST_P1_END:   w = '{OP_ZERO_K,     C_NEVER,       ST_IDLE};
			ST_CLR1:     w = '{OP_CLEAR,      C_CLR_BUSY,    ST_CLR1};
			ST_P2_RD:    w = '{OP_P2_RD,      C_K_EQ_AGENTS, ST_P3_INIT};
			ST_P2_CHK:   w = '{OP_P2_CHK,     C_CUR_OFF,     ST_P2_NEXT};
			ST_P2_WR:    w = '{OP_P2_WR,      C_NEVER,       ST_IDLE};
			ST_P2_NEXT:  w = '{OP_INC_K,      C_ALWAYS,      ST_P2_RD};
			ST_P3_INIT:  w = '{OP_ZERO_K,     C_NEVER,       ST_IDLE};
			ST_P3_TOP:   w = '{OP_LOAD_A,     C_K_EQ_CNT,    ST_OUT_INIT};
			ST_P3_RDA:   w = '{OP_RD_A,       C_NEVER,       ST_IDLE};
			ST_P3_CHKA:  w = '{OP_P3_CHKA,    C_PROP_OFF,    ST_P3_NEXT};
			ST_P3_OWN:   w = '{OP_LOAD_OTHER, C_NO_OTHER,    ST_P3_NEXT};
			ST_P3_RDO:   w = '{OP_RD_OTHER,   C_NEVER,       ST_IDLE};
			ST_P3_DEC:   w = '{OP_P3_DEC,     C_NEVER,       ST_IDLE};
			ST_P3_NEXT:  w = '{OP_INC_K,      C_ALWAYS,      ST_P3_TOP};
			ST_OUT_INIT: w = '{OP_ZERO_K,     C_NEVER,       ST_IDLE};
			ST_OUT_TOP:  w = '{OP_LOAD_A,     C_K_EQ_CNT,    ST_OUT_END};
			ST_OUT_RD:   w = '{OP_RD_A,       C_NEVER,       ST_IDLE};
			ST_OUT_EMIT: w = '{OP_EMIT,       C_ALWAYS,      ST_OUT_TOP};
			ST_OUT_END:  w = '{OP_ZERO_K,     C_NEVER,       ST_IDLE};
			ST_CLR2:     w = '{OP_CLEAR,      C_CLR_BUSY,    ST_CLR2};
			ST_FINISH:   w = '{OP_END_BATCH,  C_ALWAYS,      ST_IDLE};
			default:     w = '{OP_NOP,        C_ALWAYS,      ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/mcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the cell tables and the owner map.
module mcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH)-1:0]        waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH)-1:0]        raddr,
	output logic [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/mcr_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on mcr_pkg for the control store and the step, operation, condition and flag types.
module mcr_sequencer import mcr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output op_t    op,
	output logic   busy
);

	step_t upc_q;
	step_t upc_next;
	ctrl_t ctrl;
	logic  take;

	assign ctrl = mc_rom(upc_q);

	// Next step.
	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_K_EQ_CNT:    take = flags.k_eq_cnt;
			C_K_EQ_AGENTS: take = flags.k_eq_agents;
			C_PROP_OFF:    take = flags.prop_off;
			C_CUR_OFF:     take = flags.cur_off;
			C_NO_OTHER:    take = flags.no_other;
			C_CLR_BUSY:    take = flags.clr_busy;
			C_SWEEP_BUSY:  take = flags.sweep_busy;
			C_NOT_GO:      take = flags.not_go;
			default:       take = 1'b0;
		endcase
		upc_next = take ? ctrl.target : step_t'(upc_q + 5'd1);
	end

	// Outputs.
	always_comb begin
		op   = ctrl.op;
		busy = (upc_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_INIT;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

// ===== sv/mcr_datapath.sv =====
// Datapath of the resolver: load tables, cell and owner memories, loop registers, outputs.
// Depends on mcr_pkg and instantiates mcr_ram three times.
module mcr_datapath import mcr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  op_t                 op,
	input  logic                start,
	input  logic [AGENT_W-1:0]  agent_number,
	input  logic [COORD_W-1:0]  cur_x,
	input  logic [COORD_W-1:0]  cur_y,
	input  logic                cur_valid,
	input  logic [COORD_W-1:0]  want_x,
	input  logic [COORD_W-1:0]  want_y,
	input  logic                want_valid,
	input  logic                last_item,
	output flags_t              flags,
	output logic                result_valid,
	output logic [AGENT_W-1:0]  agent_out,
	output logic [COORD_W-1:0]  final_x,
	output logic [COORD_W-1:0]  final_y,
	output logic                final_valid,
	output logic                last_result
);

	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       tcnt_q;
	logic [AGENTS-1:0]      ld_q;
	map_addr_t              sweep_q;
	logic                   result_valid_q;
	logic [AGENT_IDX_W-1:0] plist_q [AGENTS];
	map_addr_t              tl_q [AGENTS];
	logic [AGENT_IDX_W-1:0] a_q;
	logic [AGENT_IDX_W-1:0] other_q;
	logic [AGENT_IDX_W-1:0] rd_agent_q;
	cell_t                  ca_q;
	cell_t                  pa_q;
	logic [AGENT_W-1:0]     agent_out_q;
	logic [COORD_W-1:0]     final_x_q;
	logic [COORD_W-1:0]     final_y_q;
	logic                   final_valid_q;
	logic                   last_result_q;

	logic [CELL_W-1:0]      cur_rdata;
	logic [CELL_W-1:0]      prop_rdata;
	logic [OWN_W-1:0]       own_rdata;
	cell_t                  cur_cell;
	cell_t                  prop_cell;
	own_t                   own;
	cell_t                  in_cur;
	cell_t                  in_prop;
	logic [AGENT_IDX_W-1:0] in_idx;
	logic                   store_ok;
	logic                   clr_busy;
	logic                   track;

	logic                   cell_re;
	logic [AGENT_IDX_W-1:0] cell_ra;
	logic                   cur_we;
	logic                   prop_we;
	logic [AGENT_IDX_W-1:0] prop_wa;
	cell_t                  prop_wd;
	logic                   own_re;
	map_addr_t              own_ra;
	logic                   own_we;
	map_addr_t              own_wa;
	own_t                   own_wd;

	// Cells of agents not loaded in this batch read as absent.
	assign cur_cell  = ld_q[rd_agent_q] ? cell_t'(cur_rdata)  : '0;
	assign prop_cell = ld_q[rd_agent_q] ? cell_t'(prop_rdata) : '0;
	assign own       = own_t'(own_rdata);

	assign in_cur   = cur_valid  ? cell_t'{1'b1, cur_y, cur_x}   : '0;
	assign in_prop  = want_valid ? cell_t'{1'b1, want_y, want_x} : '0;
	assign in_idx   = agent_number[AGENT_IDX_W-1:0];
	assign store_ok = (32'(agent_number) < AGENTS) && (cnt_q < CNT_W'(AGENTS));
	assign clr_busy = (k_q < tcnt_q);
	// A newly claimed cell is remembered so that it can be emptied later.
	assign track    = !own.valid && (tcnt_q < CNT_W'(AGENTS));

	always_comb begin
		flags.k_eq_cnt    = (k_q == cnt_q);
		flags.k_eq_agents = (k_q == CNT_W'(AGENTS));
		flags.prop_off    = !cell_on_map(prop_cell);
		flags.cur_off     = !cell_on_map(cur_cell);
		flags.no_other    = !own.valid || (own.id == a_q);
		flags.clr_busy    = clr_busy;
		flags.sweep_busy  = (sweep_q != MAP_AW'(MAP_DEPTH - 1));
		flags.not_go      = !(start && last_item);
	end

	// Memory port control.
	always_comb begin
		cell_re = 1'b0;
		cell_ra = a_q;
		cur_we  = 1'b0;
		prop_we = 1'b0;
		prop_wa = a_q;
		prop_wd = ca_q;
		own_re  = 1'b0;
		own_ra  = cell_addr(prop_cell);
		own_we  = 1'b0;
		own_wa  = sweep_q;
		own_wd  = '0;
		unique case (op)
			OP_LOAD: begin
				if (start && store_ok) begin
					cur_we  = 1'b1;
					prop_we = 1'b1;
					prop_wa = in_idx;
					prop_wd = in_prop;
				end
			end
			OP_RD_A: begin
				cell_re = 1'b1;
			end
			OP_RD_OTHER: begin
				cell_re = 1'b1;
				cell_ra = other_q;
			end
			OP_P2_RD: begin
				cell_re = 1'b1;
				cell_ra = k_q[AGENT_IDX_W-1:0];
			end
			OP_P1_CHK, OP_P3_CHKA: begin
				own_re = 1'b1;
			end
			OP_P2_CHK: begin
				own_re = 1'b1;
				own_ra = cell_addr(cur_cell);
			end
			OP_P1_DEC: begin
				if (own.valid) begin
					prop_we = 1'b1;
				end else begin
					own_we = 1'b1;
					own_wa = cell_addr(pa_q);
					own_wd = '{valid: 1'b1, id: a_q};
				end
			end
			OP_P2_WR: begin
				own_we = 1'b1;
				own_wa = cell_addr(ca_q);
				own_wd = '{valid: 1'b1, id: a_q};
			end
			OP_P3_DEC: begin
				if (prop_cell.valid) begin
					if (prop_cell == ca_q) begin
						// Head-on swap: the other agent goes back.
						prop_we = 1'b1;
						prop_wa = other_q;
						prop_wd = cur_cell;
					end else if (prop_cell == cur_cell && pa_q == cur_cell) begin
						// The owner stays put, so this agent stays too.
						prop_we = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				if (clr_busy) begin
					own_we = 1'b1;
					own_wa = tl_q[k_q[AGENT_IDX_W-1:0]];
				end
			end
			OP_SWEEP: begin
				own_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mcr_ram #(.WIDTH(CELL_W), .DEPTH(AGENTS)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (in_idx),
		.wdata (in_cur),
		.re    (cell_re),
		.raddr (cell_ra),
		.rdata (cur_rdata)
	);

	mcr_ram #(.WIDTH(CELL_W), .DEPTH(AGENTS)) u_prop_ram (
		.clk   (clk),
		.we    (prop_we),
		.waddr (prop_wa),
		.wdata (prop_wd),
		.re    (cell_re),
		.raddr (cell_ra),
		.rdata (prop_rdata)
	);

	mcr_ram #(.WIDTH(OWN_W), .DEPTH(MAP_DEPTH)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (own_wa),
		.wdata (own_wd),
		.re    (own_re),
		.raddr (own_ra),
		.rdata (own_rdata)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q            <= '0;
			cnt_q          <= '0;
			tcnt_q         <= '0;
			ld_q           <= '0;
			sweep_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (op == OP_EMIT);
			unique case (op)
				OP_LOAD: begin
					if (start && store_ok) begin
						cnt_q        <= CNT_W'(cnt_q + 1'b1);
						ld_q[in_idx] <= 1'b1;
					end
				end
				OP_P1_DEC, OP_P2_WR: begin
					if (track && (op == OP_P2_WR || !own.valid)) begin
						tcnt_q <= CNT_W'(tcnt_q + 1'b1);
					end
				end
				OP_INC_K, OP_EMIT: begin
					k_q <= CNT_W'(k_q + 1'b1);
				end
				OP_ZERO_K: begin
					k_q <= '0;
				end
				OP_CLEAR: begin
					if (clr_busy) begin
						k_q <= CNT_W'(k_q + 1'b1);
					end else begin
						k_q    <= '0;
						tcnt_q <= '0;
					end
				end
				OP_SWEEP: begin
					sweep_q <= MAP_AW'(sweep_q + 1'b1);
				end
				OP_END_BATCH: begin
					ld_q  <= '0;
					cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cell_re) begin
			rd_agent_q <= cell_ra;
		end
		unique case (op)
			OP_LOAD: begin
				if (start && store_ok) begin
					plist_q[cnt_q[AGENT_IDX_W-1:0]] <= in_idx;
				end
			end
			OP_LOAD_A: begin
				a_q <= plist_q[k_q[AGENT_IDX_W-1:0]];
			end
			OP_P2_RD: begin
				a_q <= k_q[AGENT_IDX_W-1:0];
			end
			OP_P1_CHK, OP_P3_CHKA: begin
				ca_q <= cur_cell;
				pa_q <= prop_cell;
			end
			OP_P2_CHK: begin
				ca_q <= cur_cell;
			end
			OP_P1_DEC, OP_P2_WR: begin
				if (track) begin
					tl_q[tcnt_q[AGENT_IDX_W-1:0]] <= own_wa;
				end
			end
			OP_LOAD_OTHER: begin
				other_q <= own.id;
			end
			OP_EMIT: begin
				agent_out_q   <= AGENT_W'(a_q);
				final_x_q     <= prop_cell.valid ? prop_cell.x : '0;
				final_y_q     <= prop_cell.valid ? prop_cell.y : '0;
				final_valid_q <= prop_cell.valid;
				last_result_q <= (CNT_W'(k_q + 1'b1) == cnt_q);
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign agent_out    = agent_out_q;
	assign final_x      = final_x_q;
	assign final_y      = final_y_q;
	assign final_valid  = final_valid_q;
	assign last_result  = last_result_q;

endmodule

// ===== sv/move_conflict_resolver.sv =====
// Top level of the move conflict resolver: sequencer plus datapath, and checks.
// Depends on mcr_pkg, mcr_sequencer and mcr_datapath.
//
// Usage. A batch of agents is loaded one transaction per agent, highest priority first.
// A transaction is taken at a rising edge where start is high and busy is low; the agent
// with last_item set closes the batch. Loading transactions may follow each other back to back.
// After the closing transaction busy rises and a microprogram runs three passes over the
// batch: first-come claims of proposed cells, an owner map built from current cells, and
// the breaking of head-on swaps and of moves into the cell of an agent that stays put.
// The passes are paced by the single read port of the cell memories and of the owner map:
// pass one and pass three step through the stored agents one at a time, pass two through
// each of the 16 agent slots, and between passes one and two the owner map is emptied of
// the cells that pass one claimed. Results then leave one at a time in load order, each
// shown for one cycle with result_valid high; last_result marks the final one. The
// receiver cannot stall them. After the results the owner map is emptied again and busy
// falls. Reset clears all control state; afterwards busy stays high while the owner map
// is swept empty, one entry per cycle.
module move_conflict_resolver import mcr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [AGENT_W-1:0]  agent_number,
	input  logic [COORD_W-1:0]  cur_x,
	input  logic [COORD_W-1:0]  cur_y,
	input  logic                cur_valid,
	input  logic [COORD_W-1:0]  want_x,
	input  logic [COORD_W-1:0]  want_y,
	input  logic                want_valid,
	input  logic                last_item,
	output logic                result_valid,
	output logic [AGENT_W-1:0]  agent_out,
	output logic [COORD_W-1:0]  final_x,
	output logic [COORD_W-1:0]  final_y,
	output logic                final_valid,
	output logic                last_result
);

	op_t    op;
	flags_t flags;

	// The sequencer steps through the control store and hands one operation per cycle
	// to the datapath; the datapath answers with the flags that the jumps test.
	mcr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op),
		.busy   (busy)
	);

	mcr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.start        (start),
		.agent_number (agent_number),
		.cur_x        (cur_x),
		.cur_y        (cur_y),
		.cur_valid    (cur_valid),
		.want_x       (want_x),
		.want_y       (want_y),
		.want_valid   (want_valid),
		.last_item    (last_item),
		.flags        (flags),
		.result_valid (result_valid),
		.agent_out    (agent_out),
		.final_x      (final_x),
		.final_y      (final_y),
		.final_valid  (final_valid),
		.last_result  (last_result)
	);

	// Results only appear while a batch is being resolved.
	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> busy)
		else $error("result strobe outside of batch resolution");

	// The closing transaction of a batch starts the resolution.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_item) |=> busy)
		else $error("closing transaction did not start resolution");

	// A transaction that does not close the batch leaves the block ready for the next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_item) |=> !busy)
		else $error("block went busy on a loading transaction");

endmodule
